@@ src/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that antecedent implies consequent in the following cycle.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tslcd_pkg.sv @@
`default_nettype none
package tslcd_pkg;

  localparam int VRAM_BYTES_DEF       = 8192;
  localparam int OBJECT_COUNT_DEF     = 40;
  localparam int OBJECTS_PER_LINE_DEF = 10;
  localparam int SCREEN_WIDTH_DEF     = 160;
  localparam int SCREEN_HEIGHT_DEF    = 144;
  localparam int LINE_CYCLES_DEF      = 456;
  localparam logic [7:0] LAST_LINE_END = 8'd154;

  typedef enum logic [1:0] {
    FUNC_VRAM_WR = 2'd0,
    FUNC_OBJ_WR  = 2'd1,
    FUNC_RENDER  = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_CONTROL   = 3'd0,
    CFG_SCROLL_X  = 3'd1,
    CFG_SCROLL_Y  = 3'd2,
    CFG_BG_PAL    = 3'd3,
    CFG_OBJ_PAL0  = 3'd4,
    CFG_OBJ_PAL1  = 3'd5,
    CFG_LYC       = 3'd6,
    CFG_LYC_IRQ   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } lcd_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_BG_MAP,
    ST_BG_LO,
    ST_BG_HI,
    ST_BG_DONE,
    ST_OBJ_Y,
    ST_OBJ_X,
    ST_OBJ_T,
    ST_OBJ_F,
    ST_OBJ_LO,
    ST_OBJ_HI,
    ST_OBJ_EVAL,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [7:0]  column;
    logic [8:0]  cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] shade;
    logic       pixel_valid;
    logic [7:0] line;
    logic [1:0] mode;
    logic       compare_match;
    logic       vblank_irq;
    logic       status_irq;
    logic       line_finished;
  } out_item_t;

  function automatic logic [7:0] grey(input logic [7:0] pal, input logic [1:0] c);
    logic [1:0] s;
    s = pal[{c, 1'b0} +: 2];
    case (s)
      2'd0:    grey = 8'd255;
      2'd1:    grey = 8'd192;
      2'd2:    grey = 8'd96;
      default: grey = 8'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ src/tile_sprite_lcd_controller_top.sv @@
`default_nettype none
// Channel | Ports                            | Moves
// in      | in_valid, in_ready, in_data      | one request item (write, render, tick)
// out     | out_valid, out_ready, out_data   | one result item per request
// cfg     | cfg_we, cfg_index, cfg_wdata     | register write, no wait
// Sequence: writes go straight to the finish step; ticks repeat the tick step for
//   each ended line. Renders read the background, then, with objects on, each object
//   entry (up to OBJECTS_PER_LINE on the line) and the tile bytes of one that covers
//   the column; the single VRAM and OAM read ports set this.
// Reset: rst_n synchronous, clears line, cycle, match flag, mode and registers;
//   both memories stay undefined until written, no clearing pass.
// Stalls: one output register; the next item is taken while a result waits.
module tile_sprite_lcd_controller_top #(
  parameter int VRAM_BYTES       = tslcd_pkg::VRAM_BYTES_DEF,
  parameter int OBJECT_COUNT     = tslcd_pkg::OBJECT_COUNT_DEF,
  parameter int OBJECTS_PER_LINE = tslcd_pkg::OBJECTS_PER_LINE_DEF,
  parameter int SCREEN_WIDTH     = tslcd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT    = tslcd_pkg::SCREEN_HEIGHT_DEF,
  parameter int LINE_CYCLES      = tslcd_pkg::LINE_CYCLES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  tslcd_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output tslcd_pkg::out_item_t  out_data,
  input  wire                   cfg_we,
  input  wire [2:0]             cfg_index,
  input  wire [7:0]             cfg_wdata
);
  import tslcd_pkg::*;

  localparam int OBJ_BYTES = OBJECT_COUNT * 4;
  localparam int OAW       = $clog2(OBJ_BYTES);
  localparam int OIW       = $clog2(OBJECT_COUNT + 1);
  localparam int FW        = $clog2(OBJECTS_PER_LINE + 1);
  localparam int VAW       = $clog2(VRAM_BYTES);

  // memories
  logic [7:0] vram [VRAM_BYTES];
  logic [7:0] oam  [OBJ_BYTES];
  logic [7:0] vram_q, oam_q;
  logic [VAW-1:0] vram_ra;
  logic [OAW-1:0] oam_ra;
  logic vram_we, oam_we;

  // registers
  logic [7:0] control_r, scx_r, scy_r, bgp_r, obp0_r, obp1_r, lyc_r;
  logic       lyc_irq_r;
  logic [7:0] line_r, line_nxt;
  logic [8:0] lcyc_r, lcyc_nxt;
  logic       match_r, match_nxt;
  logic [1:0] mode_r, mode_nxt;

  state_t     state_r, state_nxt;
  in_item_t   req_r;
  logic [9:0] clk_acc_r, clk_acc_nxt;
  logic       vb_r, vb_nxt, st_r, st_nxt, fin_r, fin_nxt;

  logic [1:0] bg_col_r, bg_col_nxt;
  logic [7:0] shade_r, shade_nxt;
  logic [7:0] blo_r, blo_nxt;
  logic [VAW-1:0] bg_hi_a_r, bg_hi_a_nxt;
  logic [OIW-1:0] oi_r, oi_nxt;
  logic [FW-1:0]  found_r, found_nxt;
  logic [7:0] sy_r, sy_nxt, sx_r, sx_nxt, tile_r, tile_nxt;
  logic       have_r, have_nxt;
  logic [7:0] best_x_r, best_x_nxt, best_f_r, best_f_nxt;
  logic [1:0] best_c_r, best_c_nxt;
  logic [7:0] flags_r, flags_nxt;

  logic       out_valid_r;
  out_item_t  out_r;
  logic       res_load;
  out_item_t  res;

  // object tile fetch: lo byte captured in EVAL, hi byte arrives in the following cycle
  logic [7:0] olo_r;
  logic       eval2_r;
  logic [1:0] oc2;

  // memory ports
  always_ff @(posedge clk) begin
    if (vram_we) vram[req_r.address[VAW-1:0]] <= req_r.write_data;
    vram_q <= vram[vram_ra];
  end
  always_ff @(posedge clk) begin
    if (oam_we) oam[req_r.address[OAW-1:0]] <= req_r.write_data;
    oam_q <= oam[oam_ra];
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= '0; scx_r <= '0; scy_r <= '0; bgp_r <= '0;
      obp0_r <= '0; obp1_r <= '0; lyc_r <= '0; lyc_irq_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CONTROL:  control_r <= cfg_wdata;
        CFG_SCROLL_X: scx_r     <= cfg_wdata;
        CFG_SCROLL_Y: scy_r     <= cfg_wdata;
        CFG_BG_PAL:   bgp_r     <= cfg_wdata;
        CFG_OBJ_PAL0: obp0_r    <= cfg_wdata;
        CFG_OBJ_PAL1: obp1_r    <= cfg_wdata;
        CFG_LYC:      lyc_r     <= cfg_wdata;
        CFG_LYC_IRQ:  lyc_irq_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // background address math
  logic [7:0]  my, mx;
  logic [12:0] map_a, bg_base, bg_lo_a;
  assign my = scy_r + line_r;
  assign mx = scx_r + req_r.column;
  assign map_a = (control_r[3] ? 13'h1C00 : 13'h1800) + {3'd0, my[7:3], mx[7:3]};
  assign bg_base = control_r[4] ? {1'b0, vram_q, 4'd0}
                 : (13'h1000 + {{1{vram_q[7]}}, vram_q, 4'd0});
  assign bg_lo_a = bg_base + {8'd0, my[2:0], 1'b0};

  // object math
  logic        obj_tall;
  logic [8:0]  ly16, obj_h;
  logic        on_line, covers;
  logic [8:0]  col8;
  logic [2:0]  opx;
  logic [3:0]  opy_raw, opy;
  logic [12:0] obj_lo_a;
  logic [2:0]  bit_sel;
  logic [7:0]  obj_tile;
  assign obj_tall = control_r[2];
  assign obj_h    = obj_tall ? 9'd16 : 9'd8;
  assign ly16     = {1'b0, line_r} + 9'd16;
  assign on_line  = ({1'b0, oam_q} <= ly16) && (({1'b0, oam_q} + obj_h) > ly16);
  assign col8     = {1'b0, req_r.column} + 9'd8;
  assign covers   = (col8 >= {1'b0, sx_r}) && ({1'b0, req_r.column} < {1'b0, sx_r});
  assign opy_raw  = 4'(ly16 - {1'b0, sy_r});
  assign opy      = flags_r[6] ? (4'(obj_h - 9'd1) - opy_raw) : opy_raw;
  assign obj_tile = obj_tall ? {tile_r[7:1], opy[3]} : tile_r;
  assign obj_lo_a = {1'b0, obj_tile, 4'd0} + {9'd0, opy[2:0], 1'b0};
  assign opx      = 3'(col8 - {1'b0, sx_r});
  assign bit_sel  = flags_r[5] ? opx : (3'd7 - opx);
  logic [2:0] bg_bit;
  assign bg_bit = 3'd7 - mx[2:0];

  logic [OAW-1:0] oi_base;
  assign oi_base = OAW'({oi_r, 2'b00});

  // tick math
  logic [7:0] line_inc;
  assign line_inc = (line_r + 8'd1 >= LAST_LINE_END) ? 8'd0 : line_r + 8'd1;

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_r <= '0; lcyc_r <= '0; match_r <= 1'b0; mode_r <= '0;
    end else begin
      state_r <= state_nxt;
      line_r <= line_nxt; lcyc_r <= lcyc_nxt; match_r <= match_nxt; mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    clk_acc_r <= clk_acc_nxt; vb_r <= vb_nxt; st_r <= st_nxt; fin_r <= fin_nxt;
    bg_col_r <= bg_col_nxt; shade_r <= shade_nxt; blo_r <= blo_nxt;
    bg_hi_a_r <= bg_hi_a_nxt;
    oi_r <= oi_nxt; found_r <= found_nxt; sy_r <= sy_nxt; sx_r <= sx_nxt;
    tile_r <= tile_nxt; flags_r <= flags_nxt; have_r <= have_nxt;
    best_x_r <= best_x_nxt; best_c_r <= best_c_nxt; best_f_r <= best_f_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OBJ_EVAL) olo_r <= vram_q;
    eval2_r <= (state_r == ST_OBJ_EVAL) && rst_n;
  end
  assign oc2 = {vram_q[bit_sel], olo_r[bit_sel]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        unique case (func_t'(in_data.func))
          FUNC_RENDER: state_nxt = ST_BG_MAP;
          FUNC_TICK:   state_nxt = ST_TICK;
          default:     state_nxt = ST_FINISH;
        endcase
      end
      ST_TICK:    if (clk_acc_r < 10'(LINE_CYCLES)) state_nxt = ST_FINISH;
      ST_BG_MAP:  state_nxt = ST_BG_LO;
      ST_BG_LO:   state_nxt = ST_BG_HI;
      ST_BG_HI:   state_nxt = ST_BG_DONE;
      ST_BG_DONE: state_nxt = ST_OBJ_Y;
      ST_OBJ_Y:   state_nxt = (!control_r[1] || oi_r >= OIW'(OBJECT_COUNT)
                              || found_r >= FW'(OBJECTS_PER_LINE)) ? ST_FINISH : ST_OBJ_X;
      ST_OBJ_X:   state_nxt = on_line ? ST_OBJ_T : ST_OBJ_Y;
      ST_OBJ_T:   state_nxt = ST_OBJ_F;
      ST_OBJ_F:   state_nxt = ST_OBJ_LO;
      ST_OBJ_LO:  state_nxt = covers ? ST_OBJ_HI : ST_OBJ_Y;
      ST_OBJ_HI:  state_nxt = ST_OBJ_EVAL;
      ST_OBJ_EVAL: state_nxt = ST_OBJ_Y;
      ST_FINISH:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    vram_we = 1'b0; oam_we = 1'b0;
    vram_ra = '0; oam_ra = oi_base;
    line_nxt = line_r; lcyc_nxt = lcyc_r; match_nxt = match_r; mode_nxt = mode_r;
    clk_acc_nxt = clk_acc_r; vb_nxt = vb_r; st_nxt = st_r; fin_nxt = fin_r;
    bg_col_nxt = bg_col_r; shade_nxt = shade_r; blo_nxt = blo_r;
    bg_hi_a_nxt = bg_hi_a_r;
    oi_nxt = oi_r; found_nxt = found_r; sy_nxt = sy_r; sx_nxt = sx_r;
    tile_nxt = tile_r; flags_nxt = flags_r; have_nxt = have_r;
    best_x_nxt = best_x_r; best_c_nxt = best_c_r; best_f_nxt = best_f_r;
    res_load = 1'b0;
    res = '0;
    unique case (state_r)
      ST_IDLE: begin
        clk_acc_nxt = {1'b0, lcyc_r} + {1'b0, in_data.cycles};
        vb_nxt = 1'b0; st_nxt = 1'b0; fin_nxt = 1'b0;
        bg_col_nxt = 2'd0; shade_nxt = 8'd255;
        oi_nxt = '0; found_nxt = '0; have_nxt = 1'b0;
      end
      ST_TICK: begin
        if (clk_acc_r >= 10'(LINE_CYCLES)) begin
          clk_acc_nxt = clk_acc_r - 10'(LINE_CYCLES);
          fin_nxt = 1'b1;
          line_nxt = line_inc;
          match_nxt = (line_inc == lyc_r);
          if (line_inc == lyc_r && lyc_irq_r) st_nxt = 1'b1;
          if (line_inc == 8'(SCREEN_HEIGHT)) vb_nxt = 1'b1;
        end else begin
          lcyc_nxt = clk_acc_r[8:0];
          if (line_r >= 8'(SCREEN_HEIGHT))  mode_nxt = MODE_VBLANK;
          else if (clk_acc_r < 10'd80)      mode_nxt = MODE_OAM;
          else if (clk_acc_r < 10'd252)     mode_nxt = MODE_DRAW;
          else                              mode_nxt = MODE_HBLANK;
        end
      end
      ST_BG_MAP: vram_ra = map_a[VAW-1:0];
      ST_BG_LO: begin
        // hold the hi byte address; vram_q moves on to the lo byte next cycle
        vram_ra = bg_lo_a[VAW-1:0];
        bg_hi_a_nxt = VAW'(bg_lo_a + 13'd1);
      end
      ST_BG_HI: begin
        vram_ra = bg_hi_a_r;
        blo_nxt = vram_q;
      end
      ST_BG_DONE: begin
        if (control_r[0]) begin
          bg_col_nxt = {vram_q[bg_bit], blo_r[bg_bit]};
          shade_nxt  = grey(bgp_r, {vram_q[bg_bit], blo_r[bg_bit]});
        end
      end
      ST_OBJ_Y: begin
        oam_ra = oi_base;
        // fold in the object fetched by the previous HI/EVAL pair
        if (eval2_r && oc2 != 2'd0 && (!have_r || sx_r < best_x_r)) begin
          have_nxt   = 1'b1;
          best_x_nxt = sx_r;
          best_c_nxt = oc2;
          best_f_nxt = flags_r;
        end
      end
      ST_OBJ_X: begin
        oam_ra = oi_base + OAW'(1);
        sy_nxt = oam_q;
        if (on_line) found_nxt = found_r + FW'(1);
        else oi_nxt = oi_r + OIW'(1);
      end
      ST_OBJ_T: begin
        oam_ra = oi_base + OAW'(2);
        sx_nxt = oam_q;
      end
      ST_OBJ_F: begin
        oam_ra = oi_base + OAW'(3);
        tile_nxt = oam_q;
      end
      ST_OBJ_LO: begin
        flags_nxt = oam_q;
        oi_nxt = oi_r + OIW'(1);
      end
      ST_OBJ_HI: begin
        vram_ra = obj_lo_a[VAW-1:0];
      end
      default: ;
    endcase
    // flags_r valid from ST_OBJ_HI onward; covers uses sx_r
    if (state_r == ST_OBJ_LO) vram_ra = '0;
    if (state_r == ST_OBJ_EVAL) begin
      vram_ra = VAW'(obj_lo_a + 13'd1);
    end
    if (state_r == ST_FINISH) begin
      res.shade = 8'd0; res.pixel_valid = 1'b0;
      res.line = line_r; res.mode = mode_r; res.compare_match = match_r;
      if (req_r.func == FUNC_TICK) begin
        res.vblank_irq = vb_r; res.status_irq = st_r; res.line_finished = fin_r;
      end
      if (req_r.func == FUNC_RENDER && line_r < 8'(SCREEN_HEIGHT)
          && {1'b0, req_r.column} < 9'(SCREEN_WIDTH)) begin
        res.pixel_valid = 1'b1;
        res.shade = shade_r;
        if (have_r && !(best_f_r[7] && bg_col_r != 2'd0))
          res.shade = grey(best_f_r[4] ? obp1_r : obp0_r, best_c_r);
      end
      res_load = !out_valid_r || out_ready;
    end
    if (state_r == ST_IDLE && in_valid) begin
      if (in_data.func == FUNC_VRAM_WR) vram_we = 1'b0;
    end
    if (state_r == ST_FINISH && res_load) begin
      if (req_r.func == FUNC_VRAM_WR) vram_we = 1'b1;
      if (req_r.func == FUNC_OBJ_WR && {3'd0, req_r.address} < 16'(OBJ_BYTES)) oam_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (res_load) out_r <= res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

@@ src/tslcd_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module tslcd_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input tslcd_pkg::in_item_t  in_data,
  input wire                  out_valid,
  input wire                  out_ready,
  input tslcd_pkg::out_item_t out_data
);
  import tslcd_pkg::*;
  `CHK_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "item dropped")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `CHK_ALWAYS(a_line_range, !out_valid || out_data.line < LAST_LINE_END, "line out of range")
  `CHK_ALWAYS(a_pv_shade, !out_valid || out_data.pixel_valid || out_data.shade == 8'd0, "shade without pixel")
  `CHK_ALWAYS(a_vb_line, !out_valid || !out_data.vblank_irq || out_data.line_finished, "vblank without line end")
endmodule
bind tile_sprite_lcd_controller_top tslcd_checker u_chk (.*);
`default_nettype wire
